>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ipa_tok_pkg.sv
// ----------------------------------------------------------------------------
// IPA tokenizer package
// Transfer types, lead byte decoding and the vocabulary table.
// ----------------------------------------------------------------------------
package ipa_tok_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_W   = 24;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LEN_W   = 3;

  localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;

  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  localparam logic [ID_W-1:0] ID_NONE = 8'd0;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } in_item_t;

  typedef struct packed {
    logic            token_valid;
    logic [ID_W-1:0] token_id;
    logic            end_of_text;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } asm_result_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if (b >= LEAD_FOUR) begin
      len = LEN_FOUR;
    end else if (b >= LEAD_THREE) begin
      len = LEN_THREE;
    end else if (b >= LEAD_TWO) begin
      len = LEN_TWO;
    end else begin
      len = LEN_ONE;
    end
    return len;
  endfunction

  function automatic logic [ID_W-1:0] vocab_lookup(input logic [KEY_W-1:0] key);
    logic [ID_W-1:0] id;
    case (key)
      24'h00003B: id = 8'd1;
      24'h00003A: id = 8'd2;
      24'h00002C: id = 8'd3;
      24'h00002E: id = 8'd4;
      24'h000021: id = 8'd5;
      24'h00003F: id = 8'd6;
      24'hE28094: id = 8'd9;
      24'hE280A6: id = 8'd10;
      24'h000022: id = 8'd11;
      24'h000028: id = 8'd12;
      24'h000029: id = 8'd13;
      24'hE2809C: id = 8'd14;
      24'hE2809D: id = 8'd15;
      24'h000020: id = 8'd16;
      24'h00CC83: id = 8'd17;
      24'h00CAA3: id = 8'd18;
      24'h00CAA5: id = 8'd19;
      24'h00CAA6: id = 8'd20;
      24'h00CAA8: id = 8'd21;
      24'hE1B59D: id = 8'd22;
      24'hEAADA7: id = 8'd23;
      24'h000041: id = 8'd24;
      24'h000049: id = 8'd25;
      24'h00004F: id = 8'd31;
      24'h000051: id = 8'd33;
      24'h000053: id = 8'd35;
      24'h000054: id = 8'd36;
      24'h000057: id = 8'd39;
      24'h000059: id = 8'd41;
      24'hE1B58A: id = 8'd42;
      24'h000061: id = 8'd43;
      24'h000062: id = 8'd44;
      24'h000063: id = 8'd45;
      24'h000064: id = 8'd46;
      24'h000065: id = 8'd47;
      24'h000066: id = 8'd48;
      24'h000068: id = 8'd50;
      24'h000069: id = 8'd51;
      24'h00006A: id = 8'd52;
      24'h00006B: id = 8'd53;
      24'h00006C: id = 8'd54;
      24'h00006D: id = 8'd55;
      24'h00006E: id = 8'd56;
      24'h00006F: id = 8'd57;
      24'h000070: id = 8'd58;
      24'h000071: id = 8'd59;
      24'h000072: id = 8'd60;
      24'h000073: id = 8'd61;
      24'h000074: id = 8'd62;
      24'h000075: id = 8'd63;
      24'h000076: id = 8'd64;
      24'h000077: id = 8'd65;
      24'h000078: id = 8'd66;
      24'h000079: id = 8'd67;
      24'h00007A: id = 8'd68;
      24'h00C991: id = 8'd69;
      24'h00C990: id = 8'd70;
      24'h00C992: id = 8'd71;
      24'h00C3A6: id = 8'd72;
      24'h00CEB2: id = 8'd75;
      24'h00C994: id = 8'd76;
      24'h00C995: id = 8'd77;
      24'h00C3A7: id = 8'd78;
      24'h00C996: id = 8'd80;
      24'h00C3B0: id = 8'd81;
      24'h00CAA4: id = 8'd82;
      24'h00C999: id = 8'd83;
      24'h00C99A: id = 8'd85;
      24'h00C99B: id = 8'd86;
      24'h00C99C: id = 8'd87;
      24'h00C99F: id = 8'd90;
      24'h00C9A1: id = 8'd92;
      24'h00C9A5: id = 8'd99;
      24'h00C9A8: id = 8'd101;
      24'h00C9AA: id = 8'd102;
      24'h00CA9D: id = 8'd103;
      24'h00C9AF: id = 8'd110;
      24'h00C9B0: id = 8'd111;
      24'h00C58B: id = 8'd112;
      24'h00C9B3: id = 8'd113;
      24'h00C9B2: id = 8'd114;
      24'h00C9B4: id = 8'd115;
      24'h00C3B8: id = 8'd116;
      24'h00C9B8: id = 8'd118;
      24'h00CEB8: id = 8'd119;
      24'h00C593: id = 8'd120;
      24'h00C9B9: id = 8'd123;
      24'h00C9BE: id = 8'd125;
      24'h00C9BB: id = 8'd126;
      24'h00CA81: id = 8'd128;
      24'h00C9BD: id = 8'd129;
      24'h00CA82: id = 8'd130;
      24'h00CA83: id = 8'd131;
      24'h00CA88: id = 8'd132;
      24'h00CAA7: id = 8'd133;
      24'h00CA8A: id = 8'd135;
      24'h00CA8B: id = 8'd136;
      24'h00CA8C: id = 8'd138;
      24'h00C9A3: id = 8'd139;
      24'h00C9A4: id = 8'd140;
      24'h00CF87: id = 8'd142;
      24'h00CA8E: id = 8'd143;
      24'h00CA92: id = 8'd147;
      24'h00CA94: id = 8'd148;
      24'h00CB88: id = 8'd156;
      24'h00CB8C: id = 8'd157;
      24'h00CB90: id = 8'd158;
      24'h00CAB0: id = 8'd162;
      24'h00CAB2: id = 8'd164;
      24'hE28693: id = 8'd169;
      24'hE28692: id = 8'd171;
      24'hE28697: id = 8'd172;
      24'hE28698: id = 8'd173;
      24'hE1B5BB: id = 8'd177;
      default:    id = ID_NONE;
    endcase
    return id;
  endfunction

endpackage

>>> rtl/ipa_tok_assembler.sv
// ----------------------------------------------------------------------------
// Character assembler
// Gathers the bytes of one UTF-8 character and looks it up in the vocabulary.
// ----------------------------------------------------------------------------
module ipa_tok_assembler (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  ipa_tok_pkg::in_item_t item,
  output ipa_tok_pkg::asm_result_t result
);
  import ipa_tok_pkg::*;

  logic [KEY_W-1:0] held_r,  held_nxt;
  logic [LEN_W-1:0] len_r,   len_nxt;
  logic [LEN_W-1:0] cnt_r,   cnt_nxt;
  logic [KEY_W-1:0] held_step;
  logic [LEN_W-1:0] len_step;
  logic [LEN_W-1:0] cnt_step;
  logic             done;
  logic [ID_W-1:0]  id;

  always_comb begin
    if (len_r == LEN_NONE) begin
      len_step  = lead_length(item.text_byte);
      held_step = {{(KEY_W-BYTE_W){1'b0}}, item.text_byte};
      cnt_step  = LEN_ONE;
    end else begin
      len_step  = len_r;
      held_step = (cnt_r < LEN_THREE) ? {held_r[KEY_W-BYTE_W-1:0], item.text_byte} : held_r;
      cnt_step  = cnt_r + LEN_ONE;
    end
    done = (cnt_step >= len_step);
    id   = (done && (len_step < LEN_FOUR)) ? vocab_lookup(held_step) : ID_NONE;

    if (done || item.final_byte) begin
      held_nxt = '0;
      len_nxt  = LEN_NONE;
      cnt_nxt  = LEN_NONE;
    end else begin
      held_nxt = held_step;
      len_nxt  = len_step;
      cnt_nxt  = cnt_step;
    end

    result.emit             = (id != ID_NONE) || item.final_byte;
    result.item.token_valid = (id != ID_NONE);
    result.item.token_id    = id;
    result.item.end_of_text = item.final_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      len_r  <= LEN_NONE;
      cnt_r  <= LEN_NONE;
    end else if (step) begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/ipa_byte_stream_to_token_ids_core.sv
// ----------------------------------------------------------------------------
// IPA byte stream to token ids
// Turns a UTF-8 phoneme string into token ids, one byte a cycle unless stalled.
//
// The input channel carries one byte of the string per transfer, with
// final_byte marking its last byte. The result channel carries a token id for
// every character found in the vocabulary; unknown characters give nothing.
// The final byte always gives one result with end_of_text set, carrying the
// token of the character it completes or no token at all.
// A byte is taken into an input register, then gathered and looked up from
// that register, and any result is registered in the output register.
// One byte is taken every cycle while the receiver does not stall; the
// character state is updated from the input register, which sets this rate.
// While the receiver stalls, a byte is still taken into the input register
// if it is empty, and the block then stalls its sender until the result has
// been taken.
// Reset empties both registers and leaves no character open.
// ----------------------------------------------------------------------------
module ipa_byte_stream_to_token_ids_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ipa_tok_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ipa_tok_pkg::out_item_t out_data
);
  import ipa_tok_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        advance;
  asm_result_t result;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  ipa_tok_assembler u_asm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_valid_r && advance),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && result.emit;
      end
    end
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (advance && in_valid_r && result.emit) begin
      out_item_r <= result.item;
    end
  end

endmodule

>>> rtl/ipa_tok_checker.sv
// ----------------------------------------------------------------------------
// IPA tokenizer checker
// Port level checks on the result and input channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipa_tok_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input ipa_tok_pkg::out_item_t out_data
);
  import ipa_tok_pkg::*;

  logic in_held;
  logic out_held;
  logic flag_ok;
  logic out_marked;

  assign in_held    = in_valid && in_stall;
  assign out_held   = out_valid && out_stall;
  assign flag_ok    = out_data.token_valid == (out_data.token_id != ID_NONE);
  assign out_marked = out_data.token_valid || out_data.end_of_text;

  `ASSERT_CLK_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `ASSERT_CLK(a_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_CLK(a_id_match, out_valid |-> flag_ok, "token flag disagrees with id")
  `ASSERT_CLK(a_no_empty, out_valid |-> out_marked, "result with neither token nor end mark")
  `ASSERT_CLK(a_stall_cause, in_held |-> out_held, "input stalled without a stalled result")

endmodule

bind ipa_byte_stream_to_token_ids_core ipa_tok_checker u_ipa_tok_checker (.*);
